/* rtl/tcw_pkg.sv */
// Shared constants, codes and controller/datapath types for the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_PUT,
    DP_HOME,
    DP_FILL,
    DP_COPY,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   init_fill;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             will_scroll;
    logic             fill_last;
    logic             copy_last;
  } dp_status_t;

endpackage

/* rtl/tcw_if.sv */
// Channel interfaces of the text console writer: item request, result and attribute write.
// Depends on tcw_pkg for the field widths.
interface tcw_item_if import tcw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [CHAR_W-1:0]   character;
  logic [ADDR_W-1:0]   cell_address;

  modport source (output valid, action, character, cell_address, input ready);
  modport sink (input valid, action, character, cell_address, output ready);
endinterface

interface tcw_result_if import tcw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CELL_W-1:0]   cell_value;
  logic [ROW_W-1:0]    cursor_row;
  logic [COL_W-1:0]    cursor_column;
  logic                scrolled;

  modport source (output valid, cell_value, cursor_row, cursor_column, scrolled, input ready);
  modport sink (input valid, cell_value, cursor_row, cursor_column, scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ATTR_W-1:0]   text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink (input valid, text_attribute, output ready);
endinterface

/* rtl/tcw_datapath.sv */
// Datapath of the text console writer: screen memory, cursor, attribute and result register.
// Depends on tcw_pkg; driven by commands from tcw_ctrl.
module tcw_datapath import tcw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic                cfg_valid_i,
  input  logic [ATTR_W-1:0]   cfg_attr_i,
  input  logic [ACT_W-1:0]    action_i,
  input  logic [CHAR_W-1:0]   character_i,
  input  logic [ADDR_W-1:0]   cell_address_i,
  output logic [CELL_W-1:0]   cell_value_o,
  output logic [ROW_W-1:0]    cursor_row_o,
  output logic [COL_W-1:0]    cursor_column_o,
  output logic                scrolled_o
);

  logic [CELL_W-1:0] screen_q [CELL_COUNT];

  logic [ATTR_W-1:0] attr_q;
  logic [ACT_W-1:0]  act_q;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [ADDR_W-1:0] sw_q;
  logic              scroll_q;
  logic              copy_pend_q;
  logic [ADDR_W-1:0] copy_dst_q;
  logic [CELL_W-1:0] rdata_q;
  logic [CELL_W-1:0] cell_value_q;
  logic [ROW_W-1:0]  cursor_row_q;
  logic [COL_W-1:0]  cursor_column_q;
  logic              scrolled_q;

  logic              is_nl;
  logic [COL_W:0]    col_inc;
  logic              wrap;
  logic              last_row;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] blank;
  logic              in_range;

  assign is_nl    = (char_q == NEWLINE_CHAR);
  assign col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
  assign wrap     = is_nl || (col_inc == (COL_W+1)'(COLUMNS));
  assign last_row = (row_q == ROW_W'(ROWS - 1));
  assign cur_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign rd_addr  = (cmd_i.op == DP_COPY) ? sw_q + ADDR_W'(COLUMNS) : addr_q;
  assign blank    = {(cmd_i.init_fill ? RESET_ATTR : attr_q), SPACE_CHAR};
  assign in_range = (addr_q < ADDR_W'(CELL_COUNT));

  assign status_o.action      = act_q;
  assign status_o.will_scroll = wrap && last_row;
  assign status_o.fill_last   = (sw_q == ADDR_W'(CELL_COUNT - 1));
  assign status_o.copy_last   = (sw_q == ADDR_W'(CELL_COUNT - COLUMNS - 1));

  // A copied cell is written in the cycle after its read, behind the read pointer.
  always_ff @(posedge clk_i) begin
    if (copy_pend_q) begin
      screen_q[copy_dst_q] <= rdata_q;
    end else if (cmd_i.op == DP_FILL) begin
      screen_q[sw_q] <= blank;
    end else if (cmd_i.op == DP_PUT && !is_nl) begin
      screen_q[cur_addr] <= {attr_q, char_q};
    end
    rdata_q <= screen_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    copy_dst_q <= sw_q;
    if (cmd_i.op == DP_ACCEPT) begin
      act_q  <= action_i;
      char_q <= character_i;
      addr_q <= cell_address_i;
    end
    if (cmd_i.op == DP_RESULT) begin
      cell_value_q    <= (act_q == ACT_READ && in_range) ? rdata_q : '0;
      cursor_row_q    <= row_q;
      cursor_column_q <= col_q;
      scrolled_q      <= scroll_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= RESET_ATTR;
      row_q       <= '0;
      col_q       <= '0;
      sw_q        <= '0;
      scroll_q    <= 1'b0;
      copy_pend_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_attr_i;
      end
      copy_pend_q <= (cmd_i.op == DP_COPY);
      case (cmd_i.op)
        DP_ACCEPT: begin
          scroll_q <= 1'b0;
          sw_q     <= '0;
        end
        DP_PUT: begin
          if (wrap) begin
            col_q <= '0;
            if (last_row) begin
              scroll_q <= 1'b1;
            end else begin
              row_q <= row_q + ROW_W'(1);
            end
          end else begin
            col_q <= col_inc[COL_W-1:0];
          end
        end
        DP_HOME: begin
          row_q <= '0;
          col_q <= '0;
          sw_q  <= '0;
        end
        DP_FILL: begin
          sw_q <= status_o.fill_last ? '0 : sw_q + ADDR_W'(1);
        end
        DP_COPY: begin
          sw_q <= sw_q + ADDR_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign cell_value_o    = cell_value_q;
  assign cursor_row_o    = cursor_row_q;
  assign cursor_column_o = cursor_column_q;
  assign scrolled_o      = scrolled_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < ROW_W'(ROWS) && col_q < COL_W'(COLUMNS))
    else $error("cursor left the screen");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_q < ADDR_W'(CELL_COUNT))
    else $error("sweep pointer beyond the screen");

  a_copy_write_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_pend_q |-> cmd_i.op != DP_FILL && cmd_i.op != DP_PUT)
    else $error("copy write collides with another screen write");

endmodule

/* rtl/tcw_ctrl.sv */
// Controller of the text console writer: sequences each request and the long screen sweeps.
// Depends on tcw_pkg; drives tcw_datapath through commands and reads its status.
module tcw_ctrl import tcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLEAR,
    S_COPY,
    S_DRAIN,
    S_BLANK,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o      = '{op: DP_NONE, init_fill: 1'b0};
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_INIT: begin
        cmd_o.op        = DP_FILL;
        cmd_o.init_fill = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.action)
          ACT_PUT: begin
            cmd_o.op = DP_PUT;
            state_d  = status_i.will_scroll ? S_COPY : S_RESULT;
          end
          ACT_CLEAR: begin
            cmd_o.op = DP_HOME;
            state_d  = S_CLEAR;
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end
      S_CLEAR: begin
        cmd_o.op = DP_FILL;
        if (status_i.fill_last) begin
          state_d = S_RESULT;
        end
      end
      S_COPY: begin
        cmd_o.op = DP_COPY;
        if (status_i.copy_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_BLANK;
      end
      S_BLANK: begin
        cmd_o.op = DP_FILL;
        if (status_i.fill_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = DP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.op == DP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == DP_RESULT |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten before it was taken");

  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT |-> !in_ready_o)
    else $error("request accepted during the clearing pass");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == DP_RESULT |=> out_valid_q && state_q == S_IDLE)
    else $error("result not presented after loading");

endmodule

/* rtl/text_console_writer.sv */
// Top level of the text console writer: joins the controller and datapath to the channels.
// Depends on tcw_pkg, the interfaces in tcw_if.sv, tcw_ctrl and tcw_datapath.
//
// The block keeps an 80 by 25 text screen of 16-bit cells (attribute in the high byte,
// character in the low byte) and a cursor, and answers every request with exactly one
// result carrying the read cell (zero unless the request was a read of an address on
// the screen), the cursor after the request and a flag telling whether the screen
// scrolled. After reset the block runs a clearing pass, one cell per cycle, that fills
// the screen with spaces under attribute 15; no request is taken during it, while
// attribute writes are taken at any time. Requests are handled one at a time through
// the screen memory, which has one read port and one write port. A put or read, and an
// unused action alike, goes from acceptance through a dispatch step to the result step.
// A clear blanks one cell per cycle. A put that pushes the cursor past the bottom row
// copies 1920 cells up one row (one read and one write per cycle, pipelined), passes
// through a drain step for the last write and blanks the bottom 80 cells. The next
// request is accepted as soon as a result is loaded into the output register, even if
// that result has not been taken yet; a result that is not taken holds the block in its
// final step. The attribute register is written through its own channel, which is
// always ready, and should be written only while no request is in flight.
module text_console_writer import tcw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcw_item_if.sink     item_i,
  tcw_result_if.source result_o,
  tcw_cfg_if.sink      cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Attribute writes land directly in the datapath register.
  assign cfg_i.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_attr_i      (cfg_i.text_attribute),
    .action_i        (item_i.action),
    .character_i     (item_i.character),
    .cell_address_i  (item_i.cell_address),
    .cell_value_o    (result_o.cell_value),
    .cursor_row_o    (result_o.cursor_row),
    .cursor_column_o (result_o.cursor_column),
    .scrolled_o      (result_o.scrolled)
  );

endmodule
